// File: design/gbsg_pkg.sv
// ----------------------------------------------------------------------------
// gbsg_pkg
// Shared types and fixed-point constants for the Gaussian beam sample
// generator: register map, stage layout and per-step reciprocals.
// ----------------------------------------------------------------------------
package gbsg_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int OUT_W       = 24;
    localparam int ROUND_SHIFT = 61 - SAMPLE_BITS;
    localparam logic [31:0] SAT_LIMIT = 32'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [29:0] LN2_Q30     = 30'd744261118;
    localparam logic [34:0] FAR_LIMIT   = 35'(64'd31 * 64'd744261118);
    localparam logic [20:0] LN2_RECIP   = 21'((64'd1 << 50) / 64'd744261118);
    localparam logic [29:0] OCTANT      = 30'h2000_0000;

    localparam logic [15:0] AMP_RESET = 16'd256;

    // exp series, k = 10 down to 1, exact floor division by reciprocal
    localparam int EXP_STEPS = 10;
    localparam int EXP_SHIFT = 35;
    localparam logic [35:0] EXP_RECIP [EXP_STEPS] = '{
        36'(((64'd1 << EXP_SHIFT) + 64'd9) / 64'd10),
        36'(((64'd1 << EXP_SHIFT) + 64'd8) / 64'd9),
        36'(((64'd1 << EXP_SHIFT) + 64'd7) / 64'd8),
        36'(((64'd1 << EXP_SHIFT) + 64'd6) / 64'd7),
        36'(((64'd1 << EXP_SHIFT) + 64'd5) / 64'd6),
        36'(((64'd1 << EXP_SHIFT) + 64'd4) / 64'd5),
        36'(((64'd1 << EXP_SHIFT) + 64'd3) / 64'd4),
        36'(((64'd1 << EXP_SHIFT) + 64'd2) / 64'd3),
        36'(((64'd1 << EXP_SHIFT) + 64'd1) / 64'd2),
        36'(((64'd1 << EXP_SHIFT) + 64'd0) / 64'd1)
    };

    // sine and cosine series, six terms each, five Horner steps each
    localparam int TRIG_STEPS = 5;
    localparam int TRIG_SHIFT = 38;
    localparam logic [37:0] SIN_RECIP [TRIG_STEPS] = '{
        38'(((64'd1 << TRIG_SHIFT) + 64'd109) / 64'd110),
        38'(((64'd1 << TRIG_SHIFT) + 64'd71) / 64'd72),
        38'(((64'd1 << TRIG_SHIFT) + 64'd41) / 64'd42),
        38'(((64'd1 << TRIG_SHIFT) + 64'd19) / 64'd20),
        38'(((64'd1 << TRIG_SHIFT) + 64'd5) / 64'd6)
    };
    localparam logic [37:0] COS_RECIP [TRIG_STEPS] = '{
        38'(((64'd1 << TRIG_SHIFT) + 64'd89) / 64'd90),
        38'(((64'd1 << TRIG_SHIFT) + 64'd55) / 64'd56),
        38'(((64'd1 << TRIG_SHIFT) + 64'd29) / 64'd30),
        38'(((64'd1 << TRIG_SHIFT) + 64'd11) / 64'd12),
        38'(((64'd1 << TRIG_SHIFT) + 64'd1) / 64'd2)
    };

    // pipeline layout
    localparam int STG_ABS    = 0;
    localparam int STG_SQ     = 1;
    localparam int STG_SUM    = 2;
    localparam int STG_PROD   = 3;
    localparam int STG_SPLIT  = 4;
    localparam int STG_RANGE  = 5;
    localparam int STG_REM    = 6;
    localparam int STG_NORM   = 7;
    localparam int STG_HORNER = 8;
    localparam int STG_ENV    = STG_HORNER + 2 * EXP_STEPS;
    localparam int STG_AE     = STG_ENV + 1;
    localparam int STG_MAG    = STG_AE + 1;
    localparam int STG_OUT    = STG_MAG + 1;
    localparam int NUM_STAGES = STG_OUT + 1;

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CENTER_X      = 3'd0,
        CFG_CENTER_Y      = 3'd1,
        CFG_INV_RADIUS_SQ = 3'd2,
        CFG_AMPLITUDE     = 3'd3,
        CFG_AXIAL_PHASE   = 3'd4,
        CFG_CURVATURE     = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef struct packed {
        logic [31:0] center_x;
        logic [31:0] center_y;
        logic [31:0] inv_radius_sq;
        logic [15:0] amplitude;
        logic [31:0] axial_phase;
        logic [31:0] curvature_coeff;
    } cfg_t;

    typedef struct packed {
        logic [OUT_W-1:0] field_real;
        logic [OUT_W-1:0] field_imag;
    } res_t;

    typedef struct packed {
        logic [31:0]      ax;
        logic [31:0]      ay;
        logic [63:0]      sqx;
        logic [63:0]      sqy;
        logic [64:0]      s;
        logic [63:0]      p0;
        logic [64:0]      p1;
        logic [31:0]      cl;
        logic [31:0]      ch;
        logic             over;
        logic [35:0]      u;
        logic [31:0]      theta;
        logic             far;
        logic [34:0]      u30;
        logic [4:0]       nest;
        quad_t            quad;
        logic             swap;
        logic [29:0]      phase_red;
        logic [29:0]      x;
        logic [30:0]      yest;
        logic [4:0]       n;
        logic [29:0]      y;
        logic [29:0]      x2;
        logic [30:0]      acc;
        logic [30:0]      exp_part;
        logic [30:0]      sin_acc;
        logic [30:0]      cos_acc;
        logic [30:0]      sin_part;
        logic [30:0]      cos_part;
        logic [30:0]      env;
        logic [30:0]      sin_val;
        logic [30:0]      cos_val;
        logic [30:0]      ae;
        logic [30:0]      re_mag;
        logic [30:0]      im_mag;
        logic             re_neg;
        logic             im_neg;
        logic [61:0]      re_prod;
        logic [61:0]      im_prod;
        logic [OUT_W-1:0] field_real;
        logic [OUT_W-1:0] field_imag;
    } stage_t;

endpackage

// File: design/gaussian_beam_sample_generator_core.sv
// ----------------------------------------------------------------------------
// gaussian_beam_sample_generator_core
// TEM00 Gaussian beam field sampler: one complex sample per pixel position,
// envelope and wavefront phase from host-written beam registers.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  input     in_valid / in_stall       x_position, y_position
//  output    out_valid / out_stall     field_real, field_imag
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  One pixel per clock while in_stall is low; each pixel passes 32 pipeline
//  stages and then the two-entry output buffer, and out_valid rises once the
//  sample is written into that buffer.
//  Twenty of the 32 stages are the ten-step exp series, two stages per step.
//  rst_n clears the pipeline valid bits, output buffer and registers; amplitude resets to 256.
//  in_stall rises only when the output buffer is full; the pipeline then holds.
// ----------------------------------------------------------------------------
module gaussian_beam_sample_generator_core
    import gbsg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [31:0]            x_position,
    input  logic [31:0]            y_position,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [OUT_W-1:0]       field_real,
    output logic [OUT_W-1:0]       field_imag,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    localparam int FIFO_DEPTH = 2;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       advance;
    logic       res_valid;
    res_t       res;
    res_t       fifo_reg [FIFO_DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CENTER_X:      cfg_next.center_x        = cfg_data;
                CFG_CENTER_Y:      cfg_next.center_y        = cfg_data;
                CFG_INV_RADIUS_SQ: cfg_next.inv_radius_sq   = cfg_data;
                CFG_AMPLITUDE:     cfg_next.amplitude       = cfg_data[15:0];
                CFG_AXIAL_PHASE:   cfg_next.axial_phase     = cfg_data;
                CFG_CURVATURE:     cfg_next.curvature_coeff = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x        <= '0;
            cfg_reg.center_y        <= '0;
            cfg_reg.inv_radius_sq   <= '0;
            cfg_reg.amplitude       <= AMP_RESET;
            cfg_reg.axial_phase     <= '0;
            cfg_reg.curvature_coeff <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // pipeline moves whenever the output buffer has room
    assign advance  = (count_reg != 2'(FIFO_DEPTH));
    assign in_stall = !advance;

    gbsg_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item_valid (in_valid),
        .x_position (x_position),
        .y_position (y_position),
        .cfg        (cfg_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign push = advance && res_valid;
    assign pop  = out_valid && !out_stall;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= res;
        end
    end

    assign out_valid  = (count_reg != 2'd0);
    assign field_real = fifo_reg[rd_ptr_reg].field_real;
    assign field_imag = fifo_reg[rd_ptr_reg].field_imag;

`ifndef SYNTHESIS
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result waiting");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == 2'($past(count_reg) + 2'd1))
        else $error("output buffer lost a transaction");

    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == 2'($past(count_reg) - 2'd1))
        else $error("output buffer repeated a transaction");
`endif

endmodule

// File: design/gbsg_datapath.sv
// ----------------------------------------------------------------------------
// gbsg_datapath
// Fixed-point sample pipeline: radius squared, exp envelope, wavefront phase,
// sine and cosine series, scaling and saturation. Moves on advance only.
// ----------------------------------------------------------------------------
module gbsg_datapath
    import gbsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic        item_valid,
    input  logic [31:0] x_position,
    input  logic [31:0] y_position,
    input  cfg_t        cfg,
    output logic        res_valid,
    output res_t        res
);

    stage_t                pipe_reg  [NUM_STAGES];
    stage_t                pipe_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] valid_reg;

    logic [32:0]        dx;
    logic [32:0]        dy;
    logic signed [64:0] cl_full;
    logic [96:0]        prod_sum;
    logic [41:0]        u30_full;
    logic [35:0]        nest_prod;
    logic [60:0]        x_prod;
    logic [34:0]        yest_full;
    logic [59:0]        x2_prod;
    logic [60:0]        sin_raw;
    logic [46:0]        ae_prod;

    function automatic logic [OUT_W-1:0] scale_part(input logic [61:0] prod,
                                                    input logic neg);
        logic [62:0] rounded;
        logic [62:0] mag;
        logic [31:0] value;
        rounded = 63'(prod) + (63'd1 << (ROUND_SHIFT - 1));
        mag = rounded >> ROUND_SHIFT;
        if (mag > 63'(SAT_LIMIT))
        begin
            mag = 63'(SAT_LIMIT);
        end
        value = neg ? (32'd0 - 32'(mag)) : 32'(mag);
        return value[OUT_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[NUM_STAGES-2:0], item_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    // offsets from the beam centre and their magnitudes
    assign dx = {x_position[31], x_position} - {cfg.center_x[31], cfg.center_x};
    assign dy = {y_position[31], y_position} - {cfg.center_y[31], cfg.center_y};

    always_comb
    begin
        pipe_next[STG_ABS]    = '0;
        pipe_next[STG_ABS].ax = dx[32] ? 32'(33'd0 - dx) : dx[31:0];
        pipe_next[STG_ABS].ay = dy[32] ? 32'(33'd0 - dy) : dy[31:0];
    end

    always_comb
    begin
        pipe_next[STG_SQ]     = pipe_reg[STG_ABS];
        pipe_next[STG_SQ].sqx = 64'(pipe_reg[STG_ABS].ax) * 64'(pipe_reg[STG_ABS].ax);
        pipe_next[STG_SQ].sqy = 64'(pipe_reg[STG_ABS].ay) * 64'(pipe_reg[STG_ABS].ay);
    end

    always_comb
    begin
        pipe_next[STG_SUM]   = pipe_reg[STG_SQ];
        pipe_next[STG_SUM].s = 65'(pipe_reg[STG_SQ].sqx) + 65'(pipe_reg[STG_SQ].sqy);
    end

    // r2 times 1/w2 in two partial products, curvature term mod 2^64
    assign cl_full = $signed({{33{cfg.curvature_coeff[31]}}, cfg.curvature_coeff})
                   * $signed({33'd0, pipe_reg[STG_SUM].s[31:0]});

    always_comb
    begin
        pipe_next[STG_PROD]    = pipe_reg[STG_SUM];
        pipe_next[STG_PROD].p0 = 64'(pipe_reg[STG_SUM].s[31:0]) * 64'(cfg.inv_radius_sq);
        pipe_next[STG_PROD].p1 = 65'(pipe_reg[STG_SUM].s[64:32]) * 65'(cfg.inv_radius_sq);
        pipe_next[STG_PROD].cl = cl_full[63:32];
        pipe_next[STG_PROD].ch = cfg.curvature_coeff * pipe_reg[STG_SUM].s[63:32];
    end

    assign prod_sum = {pipe_reg[STG_PROD].p1, 32'd0} + 97'(pipe_reg[STG_PROD].p0);

    always_comb
    begin
        pipe_next[STG_SPLIT]       = pipe_reg[STG_PROD];
        pipe_next[STG_SPLIT].over  = |prod_sum[96:72];
        pipe_next[STG_SPLIT].u     = prod_sum[71:36];
        pipe_next[STG_SPLIT].theta = cfg.axial_phase + pipe_reg[STG_PROD].cl
                                   + pipe_reg[STG_PROD].ch;
    end

    // range check, estimate of the ln2 count and octant folding
    assign u30_full  = {pipe_reg[STG_SPLIT].u, 6'd0};
    assign nest_prod = 36'(u30_full[34:20]) * 36'(LN2_RECIP);

    always_comb
    begin
        pipe_next[STG_RANGE]       = pipe_reg[STG_SPLIT];
        pipe_next[STG_RANGE].far   = pipe_reg[STG_SPLIT].over
                                   || (u30_full >= 42'(FAR_LIMIT));
        pipe_next[STG_RANGE].u30   = u30_full[34:0];
        pipe_next[STG_RANGE].nest  = nest_prod[34:30];
        pipe_next[STG_RANGE].quad  = quad_t'(pipe_reg[STG_SPLIT].theta[31:30]);
        if (pipe_reg[STG_SPLIT].theta[29:0] <= OCTANT)
        begin
            pipe_next[STG_RANGE].swap      = 1'b0;
            pipe_next[STG_RANGE].phase_red = pipe_reg[STG_SPLIT].theta[29:0];
        end
        else
        begin
            pipe_next[STG_RANGE].swap      = 1'b1;
            pipe_next[STG_RANGE].phase_red =
                30'(ONE_Q30 - 31'(pipe_reg[STG_SPLIT].theta[29:0]));
        end
    end

    assign yest_full = pipe_reg[STG_RANGE].u30
                     - 35'(pipe_reg[STG_RANGE].nest) * 35'(LN2_Q30);
    assign x_prod    = 61'(pipe_reg[STG_RANGE].phase_red) * 61'(HALF_PI_Q30);

    always_comb
    begin
        pipe_next[STG_REM]      = pipe_reg[STG_RANGE];
        pipe_next[STG_REM].yest = yest_full[30:0];
        pipe_next[STG_REM].x    = x_prod[59:30];
    end

    // the estimate is at most one short
    assign x2_prod = 60'(pipe_reg[STG_REM].x) * 60'(pipe_reg[STG_REM].x);

    always_comb
    begin
        pipe_next[STG_NORM]         = pipe_reg[STG_REM];
        pipe_next[STG_NORM].x2      = x2_prod[59:30];
        pipe_next[STG_NORM].acc     = ONE_Q30;
        pipe_next[STG_NORM].sin_acc = ONE_Q30;
        pipe_next[STG_NORM].cos_acc = ONE_Q30;
        if (pipe_reg[STG_REM].yest >= 31'(LN2_Q30))
        begin
            pipe_next[STG_NORM].y = 30'(pipe_reg[STG_REM].yest - 31'(LN2_Q30));
            pipe_next[STG_NORM].n = pipe_reg[STG_REM].nest + 5'd1;
        end
        else
        begin
            pipe_next[STG_NORM].y = pipe_reg[STG_REM].yest[29:0];
            pipe_next[STG_NORM].n = pipe_reg[STG_REM].nest;
        end
    end

    // Horner steps: multiply, then reciprocal divide and subtract
    for (genvar i = 0; i < EXP_STEPS; i++)
    begin : g_horner
        localparam int SA = STG_HORNER + 2 * i;
        localparam int SB = SA + 1;

        logic [60:0] exp_mul;
        logic [66:0] exp_div;

        assign exp_mul = 61'(pipe_reg[SA-1].y) * 61'(pipe_reg[SA-1].acc);
        assign exp_div = 67'(pipe_reg[SA].exp_part) * 67'(EXP_RECIP[i]);

        if (i < TRIG_STEPS)
        begin : g_trig
            logic [60:0] sin_mul;
            logic [60:0] cos_mul;
            logic [68:0] sin_div;
            logic [68:0] cos_div;

            assign sin_mul = 61'(pipe_reg[SA-1].x2) * 61'(pipe_reg[SA-1].sin_acc);
            assign cos_mul = 61'(pipe_reg[SA-1].x2) * 61'(pipe_reg[SA-1].cos_acc);
            assign sin_div = 69'(pipe_reg[SA].sin_part) * 69'(SIN_RECIP[i]);
            assign cos_div = 69'(pipe_reg[SA].cos_part) * 69'(COS_RECIP[i]);

            always_comb
            begin
                pipe_next[SA]          = pipe_reg[SA-1];
                pipe_next[SA].exp_part = exp_mul[60:30];
                pipe_next[SA].sin_part = sin_mul[60:30];
                pipe_next[SA].cos_part = cos_mul[60:30];
            end

            always_comb
            begin
                pipe_next[SB]         = pipe_reg[SA];
                pipe_next[SB].acc     = ONE_Q30 - exp_div[65:35];
                pipe_next[SB].sin_acc = ONE_Q30 - sin_div[68:38];
                pipe_next[SB].cos_acc = ONE_Q30 - cos_div[68:38];
            end
        end
        else
        begin : g_exp_only
            always_comb
            begin
                pipe_next[SA]          = pipe_reg[SA-1];
                pipe_next[SA].exp_part = exp_mul[60:30];
            end

            always_comb
            begin
                pipe_next[SB]     = pipe_reg[SA];
                pipe_next[SB].acc = ONE_Q30 - exp_div[65:35];
            end
        end
    end

    assign sin_raw = 61'(pipe_reg[STG_ENV-1].x) * 61'(pipe_reg[STG_ENV-1].sin_acc);

    always_comb
    begin
        pipe_next[STG_ENV]     = pipe_reg[STG_ENV-1];
        pipe_next[STG_ENV].env = pipe_reg[STG_ENV-1].far ? 31'd0
                               : (pipe_reg[STG_ENV-1].acc >> pipe_reg[STG_ENV-1].n);
        if (pipe_reg[STG_ENV-1].swap)
        begin
            pipe_next[STG_ENV].sin_val = pipe_reg[STG_ENV-1].cos_acc;
            pipe_next[STG_ENV].cos_val = sin_raw[60:30];
        end
        else
        begin
            pipe_next[STG_ENV].sin_val = sin_raw[60:30];
            pipe_next[STG_ENV].cos_val = pipe_reg[STG_ENV-1].cos_acc;
        end
    end

    assign ae_prod = 47'(cfg.amplitude) * 47'(pipe_reg[STG_ENV].env);

    always_comb
    begin
        pipe_next[STG_AE]    = pipe_reg[STG_ENV];
        pipe_next[STG_AE].ae = ae_prod[46:16];
        unique case (pipe_reg[STG_ENV].quad)
            QUAD_0:
            begin
                pipe_next[STG_AE].re_mag = pipe_reg[STG_ENV].cos_val;
                pipe_next[STG_AE].re_neg = 1'b0;
                pipe_next[STG_AE].im_mag = pipe_reg[STG_ENV].sin_val;
                pipe_next[STG_AE].im_neg = 1'b0;
            end
            QUAD_1:
            begin
                pipe_next[STG_AE].re_mag = pipe_reg[STG_ENV].sin_val;
                pipe_next[STG_AE].re_neg = 1'b1;
                pipe_next[STG_AE].im_mag = pipe_reg[STG_ENV].cos_val;
                pipe_next[STG_AE].im_neg = 1'b0;
            end
            QUAD_2:
            begin
                pipe_next[STG_AE].re_mag = pipe_reg[STG_ENV].cos_val;
                pipe_next[STG_AE].re_neg = 1'b1;
                pipe_next[STG_AE].im_mag = pipe_reg[STG_ENV].sin_val;
                pipe_next[STG_AE].im_neg = 1'b1;
            end
            QUAD_3:
            begin
                pipe_next[STG_AE].re_mag = pipe_reg[STG_ENV].sin_val;
                pipe_next[STG_AE].re_neg = 1'b0;
                pipe_next[STG_AE].im_mag = pipe_reg[STG_ENV].cos_val;
                pipe_next[STG_AE].im_neg = 1'b1;
            end
            default:
            begin
                pipe_next[STG_AE].re_mag = '0;
                pipe_next[STG_AE].re_neg = 1'b0;
                pipe_next[STG_AE].im_mag = '0;
                pipe_next[STG_AE].im_neg = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        pipe_next[STG_MAG]         = pipe_reg[STG_AE];
        pipe_next[STG_MAG].re_prod = 62'(pipe_reg[STG_AE].ae) * 62'(pipe_reg[STG_AE].re_mag);
        pipe_next[STG_MAG].im_prod = 62'(pipe_reg[STG_AE].ae) * 62'(pipe_reg[STG_AE].im_mag);
    end

    always_comb
    begin
        pipe_next[STG_OUT]            = pipe_reg[STG_MAG];
        pipe_next[STG_OUT].field_real = scale_part(pipe_reg[STG_MAG].re_prod,
                                                   pipe_reg[STG_MAG].re_neg);
        pipe_next[STG_OUT].field_imag = scale_part(pipe_reg[STG_MAG].im_prod,
                                                   pipe_reg[STG_MAG].im_neg);
    end

    assign res_valid       = valid_reg[STG_OUT];
    assign res.field_real  = pipe_reg[STG_OUT].field_real;
    assign res.field_imag  = pipe_reg[STG_OUT].field_imag;

`ifndef SYNTHESIS
    a_norm_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[STG_NORM] && !pipe_reg[STG_NORM].far
        |-> (pipe_reg[STG_NORM].y < LN2_Q30) && (pipe_reg[STG_NORM].n <= 5'd30))
        else $error("ln2 reduction left remainder or count out of range");

    a_exp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[STG_ENV-1] |-> pipe_reg[STG_ENV-1].acc <= ONE_Q30)
        else $error("exp series exceeded one");

    a_trig_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[STG_AE]
        |-> (pipe_reg[STG_AE].re_mag <= ONE_Q30) && (pipe_reg[STG_AE].im_mag <= ONE_Q30))
        else $error("trig magnitude exceeded one");
`endif

endmodule
